/* hw/rtl/route_template_validator_assert.svh */
// ----------------------------------------------------------------------------
// Route template validator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROUTE_TEMPLATE_VALIDATOR_ASSERT_SVH
`define ROUTE_TEMPLATE_VALIDATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("route template validator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RTV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("route template validator assertion failed");

`endif

/* hw/rtl/rtv_pkg.sv */
// ----------------------------------------------------------------------------
// Route template validator package
// Widths, limits, character codes and the character class record.
// ----------------------------------------------------------------------------
package rtv_pkg;

  localparam int unsigned CountWidth = 12;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam logic [CountWidth-1:0] LenReset = 12'd2048;

  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChOpen  = 8'h7b;
  localparam logic [7:0] ChClose = 8'h7d;
  localparam logic [7:0] ChDot   = 8'h2e;

  typedef logic [CountWidth-1:0] count_t;

  typedef struct packed {
    logic is_slash;
    logic is_open;
    logic is_close;
    logic is_dot;
    logic is_group_char;
    logic is_path_char;
  } char_class_t;

endpackage

/* hw/rtl/rtv_char_if.sv */
// ----------------------------------------------------------------------------
// Route template validator channel interfaces
// Valid/ready channels for target bytes and for verdicts.
// ----------------------------------------------------------------------------
interface rtv_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

interface rtv_verdict_if;
  logic valid;
  logic ready;
  logic target_ok;

  modport source (output valid, output target_ok, input ready);
  modport sink   (input valid, input target_ok, output ready);
endinterface

/* hw/rtl/rtv_char_class.sv */
// ----------------------------------------------------------------------------
// Route template validator character classifier
// Maps one byte onto the classes that the scan rules test.
// ----------------------------------------------------------------------------
module rtv_char_class (
  input  logic [7:0]          char_byte_i,
  output rtv_pkg::char_class_t class_o
);

  logic alnum;
  logic punct;

  assign alnum = ((char_byte_i >= 8'h30) && (char_byte_i <= 8'h39)) ||
                 ((char_byte_i >= 8'h41) && (char_byte_i <= 8'h5a)) ||
                 ((char_byte_i >= 8'h61) && (char_byte_i <= 8'h7a));

  always_comb begin
    unique case (char_byte_i)
      8'h2d, 8'h2e, 8'h5f, 8'h7e, 8'h21, 8'h24, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h3b, 8'h3d, 8'h3a,
      8'h40, 8'h2f, 8'h3f, 8'h25, 8'h23, 8'h5b, 8'h5d: punct = 1'b1;
      default: punct = 1'b0;
    endcase
  end

  always_comb begin
    class_o.is_slash      = (char_byte_i == rtv_pkg::ChSlash);
    class_o.is_open       = (char_byte_i == rtv_pkg::ChOpen);
    class_o.is_close      = (char_byte_i == rtv_pkg::ChClose);
    class_o.is_dot        = (char_byte_i == rtv_pkg::ChDot);
    class_o.is_group_char = alnum || (char_byte_i == 8'h5f) || (char_byte_i == 8'h2d);
    class_o.is_path_char  = alnum || punct;
  end

endmodule

/* hw/rtl/route_template_validator.sv */
// ----------------------------------------------------------------------------
// Route template validator
// Scans a route target one byte per beat and gives one verdict per target.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload               Beat
// char_i    in         char_byte, is_last    one target byte
// verdict_o out        target_ok             one verdict, on each last byte
//
// One byte is taken every cycle unless the scan stage is stalled; a verdict is
// presented once the scan stage passes its last byte on to the result register.
// Reset clears the scan state and loads max_length with 2048.
// A stalled verdict holds the scan stage only when that stage holds a last byte,
// so input stalls only once the scan stage also holds a last byte.
// ----------------------------------------------------------------------------
module route_template_validator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rtv_pkg::CountWidth-1:0]      cfg_wdata_i,
  rtv_char_if.sink                            char_i,
  rtv_verdict_if.source                       verdict_o
);

  rtv_pkg::count_t max_len_q;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  rtv_pkg::count_t count_q, count_d;
  logic            group_q, group_d;
  logic            dot_q, dot_d;
  logic            err_q, err_d;

  logic out_valid_q, out_valid_d;
  logic out_ok_q, out_ok_d;

  logic s1_adv;
  logic out_free;
  rtv_pkg::char_class_t cls;

  rtv_char_class u_class (
    .char_byte_i (s1_byte_q),
    .class_o     (cls)
  );

  assign out_free     = !out_valid_q || verdict_o.ready;
  assign s1_adv       = s1_valid_q && (!s1_last_q || out_free);
  assign char_i.ready = !s1_valid_q || s1_adv;

  always_comb begin
    count_d = count_q;
    group_d = group_q;
    dot_d   = dot_q;
    err_d   = err_q;

    if ((count_q == '0) && !cls.is_slash) begin
      err_d = 1'b1;
    end

    if (count_q == rtv_pkg::CountMax) begin
      err_d = 1'b1;
    end else begin
      count_d = count_q + rtv_pkg::count_t'(1);
    end

    if (group_q) begin
      if (cls.is_close) begin
        group_d = 1'b0;
      end else if (!cls.is_group_char) begin
        err_d = 1'b1;
      end
    end else begin
      priority if (cls.is_open) begin
        group_d = 1'b1;
      end else if (cls.is_close) begin
        err_d = 1'b1;
      end else if (!cls.is_path_char) begin
        err_d = 1'b1;
        dot_d = 1'b0;
      end else if (cls.is_dot) begin
        if (dot_q) begin
          err_d = 1'b1;
        end
        dot_d = 1'b1;
      end else begin
        dot_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_ok_d    = out_ok_q;
    if (s1_adv && s1_last_q) begin
      out_valid_d = 1'b1;
      out_ok_d    = !err_d && !group_d && (count_d <= max_len_q);
    end else if (verdict_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= rtv_pkg::LenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      s1_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready && char_i.valid) begin
      s1_byte_q <= char_i.char_byte;
      s1_last_q <= char_i.is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      group_q <= 1'b0;
      dot_q   <= 1'b0;
      err_q   <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        count_q <= '0;
        group_q <= 1'b0;
        dot_q   <= 1'b0;
        err_q   <= 1'b0;
      end else begin
        count_q <= count_d;
        group_q <= group_d;
        dot_q   <= dot_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ok_q <= out_ok_d;
  end

  assign verdict_o.valid     = out_valid_q;
  assign verdict_o.target_ok = out_ok_q;

endmodule

/* hw/rtl/rtv_checker.sv */
// ----------------------------------------------------------------------------
// Route template validator checker
// Port-level properties of the validator, attached by bind.
// ----------------------------------------------------------------------------
`include "route_template_validator_assert.svh"

module rtv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_ok_i
);

  `RTV_ASSERT_NEXT(a_out_valid_held, out_valid_i && !out_ready_i, out_valid_i)
  `RTV_ASSERT_NEXT(a_out_ok_held, out_valid_i && !out_ready_i, $stable(out_ok_i))
  `RTV_ASSERT_NOW(a_ready_when_out_empty, !out_valid_i, in_ready_i)
  `RTV_ASSERT_NOW(a_stall_needs_verdict, !in_ready_i, out_valid_i && !out_ready_i)

endmodule

bind route_template_validator rtv_checker u_rtv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (char_i.ready),
  .out_valid_i (verdict_o.valid),
  .out_ready_i (verdict_o.ready),
  .out_ok_i    (verdict_o.target_ok)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Route template validator testbench
// Streams route targets byte by byte through the validator with random
// sender bursts and receiver stalls. A scoreboard predicts each verdict
// from its own scan of the bytes and compares it with the verdict beat.
// The maximum length register is swept across its extremes between phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } route_beat_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SLOW
  } stall_mode_e;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PrintLimit   = 40;

  logic            clk_i = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  rtv_pkg::count_t cfg_wdata = '0;

  rtv_char_if    char_bus ();
  rtv_verdict_if verdict_bus ();

  route_template_validator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .char_i     (char_bus),
    .verdict_o  (verdict_bus)
  );

  string path_chars =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-._~!$&'()*+,;=:@/?%#[]";
  string group_chars =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-";

  route_beat_t pending_beats[$];
  bit          expected_verdicts[$];

  // Scan state of the current target and the length limit in force.
  rtv_pkg::count_t tgt_count = '0;
  bit              in_group = 1'b0;
  bit              last_dot = 1'b0;
  bit              broken = 1'b0;
  rtv_pkg::count_t len_limit = rtv_pkg::LenReset;

  int unsigned mismatches = 0;
  int unsigned beats_taken = 0;
  int unsigned verdicts_checked = 0;
  int unsigned routes_passed = 0;
  int unsigned limits_tried = 1;

  route_beat_t drv_beat;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  stall_mode_e stall_mode = READY_ALWAYS;
  int unsigned mode_left = 0;
  bit          pred_ok;
  bit          want_ok;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit is_alnum(input logic [7:0] ch);
    return (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
  endfunction

  function automatic bit is_uri_char(input logic [7:0] ch);
    if (is_alnum(ch)) begin
      return 1'b1;
    end
    case (ch)
      "-", ".", "_", "~", "!", "$", "&", "'", "(", ")", "*", "+", ",", ";",
      "=", ":", "@", "/", "?", "%", "#", "[", "]": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Advances the scan by one byte; returns 1 when the byte closes a target.
  function automatic bit scan_route_byte(input logic [7:0] ch, input logic last,
                                         output bit ok);
    ok = 1'b0;
    if (tgt_count == '0 && ch != rtv_pkg::ChSlash) begin
      broken = 1'b1;
    end
    if (tgt_count == rtv_pkg::CountMax) begin
      broken = 1'b1;
    end else begin
      tgt_count = tgt_count + 1'b1;
    end
    if (in_group) begin
      if (ch == rtv_pkg::ChClose) begin
        in_group = 1'b0;
      end else if (!(is_alnum(ch) || ch == "_" || ch == "-")) begin
        broken = 1'b1;
      end
    end else if (ch == rtv_pkg::ChOpen) begin
      in_group = 1'b1;
    end else if (ch == rtv_pkg::ChClose) begin
      broken = 1'b1;
    end else if (!is_uri_char(ch)) begin
      broken = 1'b1;
      last_dot = 1'b0;
    end else if (ch == rtv_pkg::ChDot) begin
      if (last_dot) begin
        broken = 1'b1;
      end
      last_dot = 1'b1;
    end else begin
      last_dot = 1'b0;
    end
    if (!last) begin
      return 1'b0;
    end
    ok = !broken && !in_group && (tgt_count <= len_limit);
    tgt_count = '0;
    in_group = 1'b0;
    last_dot = 1'b0;
    broken = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PrintLimit) begin
      $display("ERROR %0t ns: %s", $time, what);
    end
  endtask

  task automatic push_beat(input logic [7:0] ch, input logic last);
    pending_beats.push_back('{ch: ch, last: last});
  endtask

  task automatic queue_text(input string s);
    int unsigned k;
    for (k = 0; k < s.len(); k++) begin
      push_beat(s[k], k == s.len() - 1);
    end
  endtask

  task automatic queue_long_target(input int unsigned len);
    int unsigned k;
    push_beat(rtv_pkg::ChSlash, len == 1);
    for (k = 1; k < len; k++) begin
      push_beat("a", k == len - 1);
    end
  endtask

  // Mostly well-formed routes with random content; about one in five is noise.
  task automatic queue_random_targets(input int unsigned beats);
    int unsigned queued;
    int unsigned len;
    int unsigned k;
    bit          noisy;
    bit          grp;
    logic [7:0]  ch;
    queued = 0;
    while (queued < beats) begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
      noisy = ($urandom_range(0, 4) == 0);
      grp = 1'b0;
      for (k = 0; k < len; k++) begin
        if (noisy || $urandom_range(0, 39) == 0) begin
          ch = 8'($urandom_range(0, 255));
        end else if (k == 0) begin
          ch = rtv_pkg::ChSlash;
        end else if (grp) begin
          if (k == len - 1 || $urandom_range(0, 3) == 0) begin
            ch = rtv_pkg::ChClose;
            grp = 1'b0;
          end else begin
            ch = group_chars[$urandom_range(0, group_chars.len() - 1)];
          end
        end else begin
          case ($urandom_range(0, 9))
            0: begin
              ch = rtv_pkg::ChOpen;
              grp = 1'b1;
            end
            1, 2: ch = rtv_pkg::ChDot;
            default: ch = path_chars[$urandom_range(0, path_chars.len() - 1)];
          endcase
        end
        push_beat(ch, k == len - 1);
      end
      queued += len;
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (pending_beats.size() != 0 || char_bus.valid || expected_verdicts.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_max_length(input rtv_pkg::count_t value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    len_limit = value;
    limits_tried++;
  endtask

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      char_bus.valid <= 1'b0;
      char_bus.char_byte <= '0;
      char_bus.is_last <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!char_bus.valid || char_bus.ready) begin
      if (gap_left != 0) begin
        char_bus.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_beats.size() != 0) begin
        drv_beat = pending_beats.pop_front();
        char_bus.valid <= 1'b1;
        char_bus.char_byte <= drv_beat.ch;
        char_bus.is_last <= drv_beat.last;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        char_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      verdict_bus.ready <= 1'b0;
      stall_mode <= READY_ALWAYS;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 2));
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        READY_ALWAYS: verdict_bus.ready <= 1'b1;
        READY_COIN:   verdict_bus.ready <= 1'($urandom_range(0, 1));
        default:      verdict_bus.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (char_bus.valid && char_bus.ready) begin
        beats_taken++;
        if (scan_route_byte(char_bus.char_byte, char_bus.is_last, pred_ok)) begin
          expected_verdicts.push_back(pred_ok);
        end
      end
      if (verdict_bus.valid && verdict_bus.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict beat arrived with no target pending");
        end else begin
          want_ok = expected_verdicts.pop_front();
          verdicts_checked++;
          if (verdict_bus.target_ok === 1'b1) begin
            routes_passed++;
          end
          if (verdict_bus.target_ok !== want_ok) begin
            report_mismatch($sformatf("target_ok is %b, predicted %b (verdict %0d)",
                                      verdict_bus.target_ok, want_ok, verdicts_checked));
          end
        end
      end
    end
  end

  initial begin
    char_bus.valid = 1'b0;
    char_bus.char_byte = '0;
    char_bus.is_last = 1'b0;
    verdict_bus.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;

    // Short directed targets under the reset length limit.
    queue_text("/");
    queue_text("x");
    queue_text("/..");
    queue_text("/.{a}.");
    queue_text("/{.}");
    queue_text("/{a");
    queue_text("/}");
    queue_text("/{{}");
    push_beat(rtv_pkg::ChSlash, 1'b0);
    push_beat(8'hff, 1'b1);
    push_beat(8'h00, 1'b1);
    wait_drained();

    // Longest limit, with a long target that stays inside it.
    set_max_length(rtv_pkg::CountMax);
    queue_long_target(120);
    queue_random_targets(300);
    wait_drained();

    set_max_length('0);
    queue_random_targets(150);
    wait_drained();

    set_max_length(rtv_pkg::count_t'(1));
    queue_text("/");
    queue_text("/a");
    queue_random_targets(250);
    wait_drained();

    set_max_length(rtv_pkg::count_t'($urandom_range(2, 12)));
    queue_random_targets(400);
    wait_drained();

    set_max_length(rtv_pkg::count_t'($urandom_range(13, 4094)));
    queue_random_targets(350);
    wait_drained();

    set_max_length(rtv_pkg::LenReset);
    queue_random_targets(300);
    wait_drained();

    if (expected_verdicts.size() != 0) begin
      report_mismatch("verdicts still outstanding at the end of the run");
    end
    $display("Streamed %0d target bytes under %0d length limits.", beats_taken, limits_tried);
    $display("Checked %0d verdicts, %0d of them accepting the route.", verdicts_checked,
             routes_passed);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Run timed out with %0d verdicts outstanding.", expected_verdicts.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
